@@ rtl/pdlf_pkg.sv @@
`default_nettype none

package pdlf_pkg;

  localparam int unsigned IdxW = 8;
  localparam int unsigned ChanW = 8;
  localparam int unsigned CoefW = 16;
  localparam int unsigned LinMaxW = 25;
  localparam int unsigned TableDepth = 256;

  localparam logic [CoefW-1:0] CoefRed = 16'd13938;
  localparam logic [CoefW-1:0] CoefGreen = 16'd46868;
  localparam logic [CoefW-1:0] CoefBlue = 16'd4730;

  typedef logic [LinMaxW-1:0] lin_word_t;
  typedef lin_word_t lin_table_t [TableDepth];

  // q0.31 fifth power, used to invert t^2 into t^0.4
  function automatic logic [63:0] pow5_q31(input logic [63:0] r);
    logic [63:0] p2;
    logic [63:0] p4;
    p2 = (r * r) >> 31;
    p4 = (p2 * p2) >> 31;
    return (p4 * r) >> 31;
  endfunction

  // srgb code to linear, q0.lb, evaluated at elaboration
  function automatic lin_table_t build_lin_table(input int unsigned lb);
    lin_table_t  tab;
    logic [63:0] num;
    logic [63:0] tn;
    logic [63:0] u;
    logic [63:0] w;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] val;
    for (int unsigned c = 0; c < TableDepth; c++) begin
      if (c <= 10) begin
        num = 64'(c) * 64'd100 * (64'd1 << lb) + 64'd164730;
        val = num / 64'd329460;
      end else begin
        tn = 64'd1000 * 64'(c) + 64'd14025;
        u = ((tn << 31) + 64'd134512) / 64'd269025;
        w = (u * u) >> 31;
        lo = 64'd0;
        hi = 64'd1 << 31;
        while (lo < hi) begin
          mid = lo + (hi - lo + 64'd1) / 64'd2;
          if (pow5_q31(mid) <= w) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
        val = (w * lo + (64'd1 << (61 - lb))) >> (62 - lb);
      end
      tab[c] = val[LinMaxW-1:0];
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

@@ rtl/palette_darkest_lightest_finder.sv @@
// palette darkest / lightest finder
// slave side takes one palette entry per request: tdata holds red, green and
// blue srgb codes, tlast marks the final entry of the palette. entries are
// numbered from zero in arrival order; an entry numbered PALETTE_SIZE-1 ends
// the palette even without tlast.
// master side gives one request per palette: tdata holds the index of the
// first entry with least relative luminance and of the first with greatest.
// throughput is one entry per cycle unless the master side holds a result back.
// each code is looked up in a registered linear rom, weighted by three
// multipliers, summed, then compared against the running extremes; the result
// goes to the output register when the closing entry is compared.
// when the master side stalls, entries keep flowing through the pipeline
// until one that closes a palette reaches the compare stage; only then does
// back pressure reach tready.
// reset clears the pipeline, the output valid and the running extremes,
// so the next entry starts a new palette.
`default_nettype none

module palette_darkest_lightest_finder
  import pdlf_pkg::*;
#(
  parameter int unsigned PALETTE_SIZE = 256,
  parameter int unsigned LINEAR_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // red[7:0], green[15:8], blue[23:16]
  input  wire logic        s_axis_tlast_i,   // last_entry
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o    // darkest_index[7:0], lightest_index[15:8]
);

  localparam int unsigned LinW = LINEAR_BITS + 1;
  localparam int unsigned ProdW = LinW + CoefW;
  localparam int unsigned LumaW = LINEAR_BITS + 17;
  localparam int unsigned CntW = (PALETTE_SIZE > 2) ? $clog2(PALETTE_SIZE) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(PALETTE_SIZE - 1);
  localparam lin_table_t LinTable = build_lin_table(LINEAR_BITS);

  logic [ChanW-1:0] red, green, blue;

  logic             v1_q, v2_q, v3_q;
  logic             last1_q, last2_q, last3_q;
  logic [LinW-1:0]  lin_r_q, lin_g_q, lin_b_q;
  logic [ProdW-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic [LumaW-1:0] luma3_q;
  logic [LumaW-1:0] luma_sum;

  logic [CntW-1:0]  cnt_q;
  logic [LumaW-1:0] least_luma_q, greatest_luma_q;
  logic [CntW-1:0]  least_idx_q, greatest_idx_q;

  logic             out_v_q;
  logic [IdxW-1:0]  out_dark_q, out_light_q;

  logic             out_free, fire3, adv1, adv2, adv3, take3;
  logic [CntW-1:0]  least_idx_d, greatest_idx_d;

  assign red = s_axis_tdata_i[7:0];
  assign green = s_axis_tdata_i[15:8];
  assign blue = s_axis_tdata_i[23:16];

  assign out_free = !out_v_q || m_axis_tready_i;
  assign fire3 = last3_q || (cnt_q == CntLast);
  assign adv3 = !v3_q || !fire3 || out_free;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign take3 = v3_q && adv3;
  assign s_axis_tready_o = adv1;

  // linear rom, one read port per channel
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      lin_r_q <= LinTable[red][LinW-1:0];
      lin_g_q <= LinTable[green][LinW-1:0];
      lin_b_q <= LinTable[blue][LinW-1:0];
      last1_q <= s_axis_tlast_i;
    end
    if (adv2) begin
      prod_r_q <= ProdW'(lin_r_q) * ProdW'(CoefRed);
      prod_g_q <= ProdW'(lin_g_q) * ProdW'(CoefGreen);
      prod_b_q <= ProdW'(lin_b_q) * ProdW'(CoefBlue);
      last2_q <= last1_q;
    end
    if (adv3) begin
      luma3_q <= luma_sum;
      last3_q <= last2_q;
    end
  end

  assign luma_sum = LumaW'(prod_r_q) + LumaW'(prod_g_q) + LumaW'(prod_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_comb begin
    least_idx_d = least_idx_q;
    greatest_idx_d = greatest_idx_q;
    if (cnt_q == '0) begin
      least_idx_d = '0;
      greatest_idx_d = '0;
    end else begin
      if (luma3_q < least_luma_q) least_idx_d = cnt_q;
      if (luma3_q > greatest_luma_q) greatest_idx_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      least_luma_q <= '0;
      greatest_luma_q <= '0;
      least_idx_q <= '0;
      greatest_idx_q <= '0;
    end else if (take3) begin
      if (fire3) begin
        cnt_q <= '0;
        least_luma_q <= '0;
        greatest_luma_q <= '0;
        least_idx_q <= '0;
        greatest_idx_q <= '0;
      end else begin
        cnt_q <= cnt_q + CntW'(1);
        least_idx_q <= least_idx_d;
        greatest_idx_q <= greatest_idx_d;
        if (cnt_q == '0 || luma3_q < least_luma_q) least_luma_q <= luma3_q;
        if (cnt_q == '0 || luma3_q > greatest_luma_q) greatest_luma_q <= luma3_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (take3 && fire3) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take3 && fire3) begin
      out_dark_q <= IdxW'(least_idx_d);
      out_light_q <= IdxW'(greatest_idx_d);
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o = {out_light_q, out_dark_q};

`ifndef ASSERT_OFF
  a_rise_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(v3_q && fire3 && adv3))
    else $error("result appeared without a closing entry");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take3 && fire3) |=> (cnt_q == '0))
    else $error("entry count not cleared after result");

  a_luma_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    least_luma_q <= greatest_luma_q)
    else $error("least luminance above greatest");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (least_idx_q <= cnt_q) && (greatest_idx_q <= cnt_q))
    else $error("tracked index beyond entry count");

  a_stall_only_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (v3_q && fire3 && out_v_q && !m_axis_tready_i))
    else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

@@ dv/palette_darkest_lightest_finder_test.sv @@
`timescale 1ns / 100ps

module palette_darkest_lightest_finder_test;

  localparam int unsigned PaletteSize = 256;
  localparam int unsigned LinBits = 16;
  localparam logic [63:0] LumaRed = 64'd13938;
  localparam logic [63:0] LumaGreen = 64'd46868;
  localparam logic [63:0] LumaBlue = 64'd4730;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned IdlePercent = 11;

  typedef struct packed {
    logic [7:0] lightest;
    logic [7:0] darkest;
  } index_pair_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;   // red[7:0], green[15:8], blue[23:16]
  logic        s_axis_tlast_i;   // last_entry
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;   // darkest_index[7:0], lightest_index[15:8]

  palette_darkest_lightest_finder #(
    .PALETTE_SIZE(PaletteSize),
    .LINEAR_BITS (LinBits)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  logic [63:0]  linear_of_code [256];
  logic [7:0]   entry_count;
  logic [63:0]  least_luma;
  logic [63:0]  greatest_luma;
  logic [7:0]   least_index;
  logic [7:0]   greatest_index;
  index_pair_t  pending_indices [$];
  index_pair_t  oldest_pair;
  int unsigned  mismatches;
  int unsigned  cycles;
  int unsigned  entries_sent;
  int unsigned  hold_cycles;
  bit           steady;

  function automatic logic [63:0] fifth_power_q31(input logic [63:0] x);
    logic [63:0] sq;
    logic [63:0] quad;
    sq = (x * x) >> 31;
    quad = (sq * sq) >> 31;
    return (quad * x) >> 31;
  endfunction

  // srgb code to linear light, rounded, q0.LinBits
  function automatic logic [63:0] code_to_linear(input int unsigned code);
    logic [63:0] t_num;
    logic [63:0] t_q31;
    logic [63:0] t_sq;
    logic [63:0] lo_b;
    logic [63:0] hi_b;
    logic [63:0] probe;
    if (code <= 10) begin
      return (64'(code) * 64'd100 * (64'd1 << LinBits) + 64'd164730) / 64'd329460;
    end
    t_num = 64'd1000 * 64'(code) + 64'd14025;
    t_q31 = ((t_num << 31) + 64'd134512) / 64'd269025;
    t_sq = (t_q31 * t_q31) >> 31;
    lo_b = 64'd0;
    hi_b = 64'd1 << 31;
    // largest root whose fifth power does not exceed t squared
    while (lo_b < hi_b) begin
      probe = lo_b + (hi_b - lo_b + 64'd1) / 64'd2;
      if (fifth_power_q31(probe) <= t_sq) begin
        lo_b = probe;
      end else begin
        hi_b = probe - 64'd1;
      end
    end
    return (t_sq * lo_b + (64'd1 << (61 - LinBits))) >> (62 - LinBits);
  endfunction

  function automatic logic [63:0] luma_of(input logic [7:0] red, input logic [7:0] green,
                                          input logic [7:0] blue);
    return LumaRed * linear_of_code[red] + LumaGreen * linear_of_code[green]
         + LumaBlue * linear_of_code[blue];
  endfunction

  task automatic track_entry(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic last_entry);
    logic [63:0] luma;
    luma = luma_of(red, green, blue);
    if (entry_count == 8'd0) begin
      least_luma = luma;
      greatest_luma = luma;
      least_index = 8'd0;
      greatest_index = 8'd0;
    end else begin
      if (luma < least_luma) begin
        least_luma = luma;
        least_index = entry_count;
      end
      if (luma > greatest_luma) begin
        greatest_luma = luma;
        greatest_index = entry_count;
      end
    end
    if (last_entry || entry_count >= 8'(PaletteSize - 1)) begin
      pending_indices.push_back('{lightest: greatest_index, darkest: least_index});
      entry_count = 8'd0;
      least_luma = 64'd0;
      greatest_luma = 64'd0;
      least_index = 8'd0;
      greatest_index = 8'd0;
    end else begin
      entry_count = entry_count + 8'd1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // called and returns at a falling edge
  task automatic send_entry(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic last_entry);
    while (!steady && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid_i = 1'b0;
      s_axis_tdata_i = 24'($urandom());
      s_axis_tlast_i = 1'($urandom());
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {blue, green, red};
    s_axis_tlast_i = last_entry;
    do @(posedge clk_i); while (!s_axis_tready_o);
    track_entry(red, green, blue, last_entry);
    entries_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_gray(input logic [7:0] level, input logic last_entry);
    send_entry(level, level, level, last_entry);
  endtask

  task automatic send_random_palette(input int unsigned size, input bit tie_heavy);
    logic [23:0] shades [4];
    logic [23:0] pick;
    foreach (shades[k]) shades[k] = 24'($urandom());
    for (int unsigned n = 0; n < size; n++) begin
      pick = (tie_heavy && $urandom_range(99) < 60) ? shades[$urandom_range(3)]
                                                     : 24'($urandom());
      send_entry(pick[7:0], pick[15:8], pick[23:16], n == size - 1);
    end
  endtask

  task automatic test_single_entry();
    send_gray(8'd0, 1'b1);
    send_gray(8'd255, 1'b1);
    send_entry(8'd0, 8'd255, 8'd0, 1'b1);
  endtask

  task automatic test_extremes();
    send_gray(8'd255, 1'b0);
    send_gray(8'd0, 1'b0);
    send_entry(8'd255, 8'd0, 8'd0, 1'b0);
    send_entry(8'd0, 8'd255, 8'd0, 1'b0);
    send_entry(8'd0, 8'd0, 8'd255, 1'b0);
    send_gray(8'd0, 1'b0);
    send_gray(8'd255, 1'b1);
  endtask

  task automatic test_ties();
    repeat (4) send_entry(8'd90, 8'd17, 8'd200, 1'b0);
    send_entry(8'd90, 8'd17, 8'd200, 1'b1);
  endtask

  // linear segment ends at code 10, power curve starts at 11
  task automatic test_curve_knee();
    send_gray(8'd11, 1'b0);
    send_gray(8'd10, 1'b0);
    send_gray(8'd12, 1'b0);
    send_gray(8'd9, 1'b0);
    send_gray(8'd1, 1'b1);
  endtask

  task automatic test_overlong_palette();
    send_random_palette(PaletteSize + 2, 1'b0);
    send_gray(8'd128, 1'b0);
    send_gray(8'd127, 1'b1);
  endtask

  task automatic test_output_stall();
    hold_cycles = 120;
    steady = 1'b1;
    repeat (10) send_random_palette($urandom_range(1, 4), 1'b0);
    steady = 1'b0;
  endtask

  task automatic test_random_palettes();
    int unsigned target;
    target = entries_sent + 260;
    steady = 1'b1;
    repeat (8) send_random_palette($urandom_range(1, 10), 1'b1);
    steady = 1'b0;
    while (entries_sent < target) begin
      if ($urandom_range(9) == 0) begin
        send_random_palette($urandom_range(11, 40), $urandom_range(1));
      end else begin
        send_random_palette($urandom_range(1, 10), $urandom_range(1));
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready_i = 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready_i = steady || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_indices.size() == 0) begin
        report_mismatch("result with none pending", m_axis_tdata_o[7:0], 8'd0);
      end else begin
        oldest_pair = pending_indices.pop_front();
        if (m_axis_tdata_o[7:0] !== oldest_pair.darkest) begin
          report_mismatch("darkest index", m_axis_tdata_o[7:0], oldest_pair.darkest);
        end
        if (m_axis_tdata_o[15:8] !== oldest_pair.lightest) begin
          report_mismatch("lightest index", m_axis_tdata_o[15:8], oldest_pair.lightest);
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = 24'd0;
    s_axis_tlast_i = 1'b0;
    mismatches = 0;
    cycles = 0;
    entries_sent = 0;
    hold_cycles = 0;
    steady = 1'b0;
    entry_count = 8'd0;
    least_luma = 64'd0;
    greatest_luma = 64'd0;
    least_index = 8'd0;
    greatest_index = 8'd0;
    for (int unsigned c = 0; c < 256; c++) linear_of_code[c] = code_to_linear(c);
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_single_entry();
    test_extremes();
    test_ties();
    test_curve_knee();
    test_output_stall();
    test_overlong_palette();
    test_random_palettes();

    s_axis_tvalid_i = 1'b0;
    s_axis_tlast_i = 1'b0;
    while (pending_indices.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
